FILE: src/i2cmsc_pkg.sv
// Shared types, constants and helpers for the I2C master/slave controller.
`default_nettype none
package i2cmsc_pkg;

    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_MCMD    = 3'd1,
        CMD_TXD     = 3'd2,
        CMD_MSTAT   = 3'd3,
        CMD_SSTAT   = 3'd4,
        CMD_SRESET  = 3'd5,
        CMD_TICK    = 3'd6,
        CMD_SEVENT  = 3'd7
    } t_cmd;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_RDNAK = 3'd4;
    localparam logic [2:0] OP_NACK  = 3'd5;
    localparam logic [2:0] OP_STOP  = 3'd6;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_MODE   = 3'd1;
    localparam logic [2:0] CFG_SPEED  = 3'd2;
    localparam logic [2:0] CFG_MIRQ   = 3'd3;
    localparam logic [2:0] CFG_SIRQ   = 3'd4;
    localparam logic [2:0] CFG_AUTO   = 3'd5;
    localparam logic [2:0] CFG_OWNADR = 3'd6;

    localparam logic [3:0] REG_CFG   = 4'd0;
    localparam logic [3:0] REG_MSCR  = 4'd1;
    localparam logic [3:0] REG_MSST  = 4'd2;
    localparam logic [3:0] REG_SLCR  = 4'd3;
    localparam logic [3:0] REG_SLST  = 4'd4;
    localparam logic [3:0] REG_SLADR = 4'd5;
    localparam logic [3:0] REG_TXD   = 4'd6;
    localparam logic [3:0] REG_RXD   = 4'd7;
    localparam logic [3:0] REG_AUX   = 4'd8;

    localparam logic [3:0] MC_START  = 4'd1;
    localparam logic [3:0] MC_SEND   = 4'd2;
    localparam logic [3:0] MC_ACKRD  = 4'd3;
    localparam logic [3:0] MC_RECV   = 4'd4;
    localparam logic [3:0] MC_NACK   = 4'd5;
    localparam logic [3:0] MC_STOP   = 4'd6;
    localparam logic [3:0] MC_STSEND = 4'd9;
    localparam logic [3:0] MC_AUTO   = 4'd10;
    localparam logic [3:0] MC_RECV2  = 4'd11;
    localparam logic [3:0] MC_RECVNK = 4'd12;

    localparam logic [7:0] SL_FLAGS    = 8'h78;
    localparam logic [7:0] STATUS_RO   = 8'h82;
    localparam logic [7:0] STATUS_RSVD = 8'h3c;
    localparam logic [7:0] RX_EMPTY    = 8'hff;

    localparam int QDEPTH = 2;

    // One classified item passed from the front end to the engine.
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] idx;
        logic [7:0] wdata;
        logic       tnack;
        logic [7:0] tbyte;
        logic [1:0] kind;
        logic [7:0] sbyte;
        logic       snack;
        logic [3:0] mcode;   // master command code to issue
        logic       issue;   // issue the code (MCMD: clocks nonzero; TXD: auto send)
    } t_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic [2:0] bus_op;
        logic [7:0] bus_byte;
        logic       done;
    } t_res;

    function automatic logic [3:0] cmd_clocks(input logic [3:0] c);
        logic [3:0] r;
        unique case (c)
            MC_START, MC_STOP:               r = 4'd2;
            MC_SEND, MC_RECV:                r = 4'd8;
            MC_ACKRD, MC_NACK:               r = 4'd1;
            MC_STSEND:                       r = 4'd11;
            MC_AUTO, MC_RECV2, MC_RECVNK:    r = 4'd9;
            default:                         r = 4'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/i2cmsc_front.sv
// Front end: accepts items, resolves the master command code, queues them.
`default_nettype none
module i2cmsc_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    output logic                   o_full,
    input  wire  [2:0]             i_command,
    input  wire  [3:0]             i_reg_index,
    input  wire  [7:0]             i_wdata,
    input  wire                    i_target_nack,
    input  wire  [7:0]             i_target_byte,
    input  wire  [1:0]             i_slave_kind,
    input  wire  [7:0]             i_slave_byte,
    input  wire                    i_slave_nack,
    input  wire                    i_auto_send,
    output logic                   o_valid,
    output i2cmsc_pkg::t_item      o_item,
    input  wire                    i_take
);
    i2cmsc_pkg::t_item r_q [i2cmsc_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    i2cmsc_pkg::t_item w_in;
    logic w_push;

    always_comb begin
        w_in.cmd   = i2cmsc_pkg::t_cmd'(i_command);
        w_in.idx   = i_reg_index;
        w_in.wdata = i_wdata;
        w_in.tnack = i_target_nack;
        w_in.tbyte = i_target_byte;
        w_in.kind  = i_slave_kind;
        w_in.sbyte = i_slave_byte;
        w_in.snack = i_slave_nack;
        if (w_in.cmd == i2cmsc_pkg::CMD_TXD) begin
            w_in.mcode = i2cmsc_pkg::MC_AUTO;
            w_in.issue = i_auto_send;
        end else begin
            w_in.mcode = i_wdata[3:0];
            w_in.issue = (w_in.cmd == i2cmsc_pkg::CMD_MCMD)
                         && (i2cmsc_pkg::cmd_clocks(i_wdata[3:0]) != 4'd0);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign w_push  = i_push && !o_full;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_take};
        end
    end
endmodule
`default_nettype wire

FILE: src/i2cmsc_engine.sv
// Back end: register file, master command engine, slave status, result queue.
`default_nettype none
module i2cmsc_engine (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [2:0]             i_cfg_index,
    input  wire  [7:0]             i_cfg_wdata,
    output logic                   o_auto_send,
    input  wire                    i_valid,
    input  i2cmsc_pkg::t_item      i_item,
    output logic                   o_take,
    output logic                   o_empty,
    input  wire                    i_pop,
    output i2cmsc_pkg::t_res       o_res
);
    logic r_en, r_mode, r_mirq, r_auto;
    logic [5:0] r_speed;
    logic [3:0] r_sirq;
    logic [7:0] r_own;

    logic [7:0] r_ms, n_ms, r_ss, n_ss, r_tx, n_tx, r_rx, n_rx;
    logic [3:0] r_last, n_last;
    logic [11:0] r_ticks, n_ticks;
    // engine flags
    logic r_act, n_act, r_bus, n_bus, r_adr, n_adr, r_rxd, n_rxd;
    logic r_lack, n_lack, r_smp, n_smp;

    i2cmsc_pkg::t_res r_oq [i2cmsc_pkg::QDEPTH];
    logic r_owp, r_orp;
    logic [1:0] r_ocnt;
    i2cmsc_pkg::t_res w_res;
    logic [7:0] w_v;
    logic [7:0] w_per;

    assign o_auto_send = r_auto;
    assign o_take  = i_valid && (r_ocnt != 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];
    // speed*2+4 reaches 130 at the slowest setting
    assign w_per   = {1'b0, r_speed, 1'b0} + 8'd4;

    always_comb begin
        n_ms = r_ms; n_ss = r_ss; n_tx = r_tx; n_rx = r_rx; n_last = r_last;
        n_ticks = r_ticks; n_act = r_act; n_bus = r_bus; n_adr = r_adr;
        n_rxd = r_rxd; n_lack = r_lack; n_smp = r_smp;
        w_res = '0; w_v = '0;
        unique case (i_item.cmd)
            i2cmsc_pkg::CMD_READ: begin
                unique case (i_item.idx)
                    i2cmsc_pkg::REG_CFG:   w_res.rdata = {r_en, r_mode, r_speed};
                    i2cmsc_pkg::REG_MSCR:  w_res.rdata = {r_mirq, 3'd0, r_last};
                    i2cmsc_pkg::REG_MSST:  w_res.rdata = r_ms;
                    i2cmsc_pkg::REG_SLCR:  w_res.rdata = {1'b0, r_sirq, 3'd0};
                    i2cmsc_pkg::REG_SLST:  w_res.rdata = r_ss;
                    i2cmsc_pkg::REG_SLADR: w_res.rdata = r_own;
                    i2cmsc_pkg::REG_TXD:   w_res.rdata = r_tx;
                    i2cmsc_pkg::REG_RXD:   w_res.rdata = r_rx;
                    i2cmsc_pkg::REG_AUX:   w_res.rdata = {7'd0, r_auto};
                    default:               w_res.rdata = 8'd0;
                endcase
            end
            i2cmsc_pkg::CMD_MSTAT: begin
                w_v = i_item.wdata & ~(i2cmsc_pkg::STATUS_RO | i2cmsc_pkg::STATUS_RSVD);
                if (w_v[6]) w_v[6] = r_ms[6];
                n_ms = (r_ms & i2cmsc_pkg::STATUS_RO) | w_v;
            end
            i2cmsc_pkg::CMD_SSTAT: begin
                w_v = i_item.wdata & ~i2cmsc_pkg::STATUS_RO & 8'hfb;
                w_v = (w_v & ~i2cmsc_pkg::SL_FLAGS) | (w_v & r_ss & i2cmsc_pkg::SL_FLAGS);
                n_ss = (r_ss & i2cmsc_pkg::STATUS_RO) | w_v;
            end
            i2cmsc_pkg::CMD_SRESET: n_ss = 8'd0;
            i2cmsc_pkg::CMD_TICK: begin
                if (r_act) begin
                    if (r_ticks <= 12'd1) begin
                        n_ticks = 12'd0;
                        n_act = 1'b0;
                        if (r_smp) n_ms[1] = r_lack;
                        n_ms[6] = 1'b1;
                        w_res.done = 1'b1;
                    end else begin
                        n_ticks = r_ticks - 12'd1;
                    end
                end
            end
            i2cmsc_pkg::CMD_SEVENT: begin
                if (r_en && !r_mode) begin
                    unique case (i_item.kind)
                        2'd0: begin n_ss[7] = 1'b1; n_ss[6] = 1'b1; end
                        2'd1: begin n_rx = i_item.sbyte; n_ss[5] = 1'b1; end
                        2'd2: begin n_ss[1] = i_item.snack; n_ss[4] = 1'b1; end
                        default: begin n_ss[7] = 1'b0; n_ss[3] = 1'b1; end
                    endcase
                end
            end
            default: ;
        endcase
        if (i_item.cmd == i2cmsc_pkg::CMD_MCMD) n_last = i_item.wdata[3:0];
        if (i_item.cmd == i2cmsc_pkg::CMD_TXD) n_tx = i_item.wdata;
        // Master command issue (explicit codes or auto send)
        if (i_item.issue && r_en && r_mode) begin
            n_act = 1'b1;
            n_smp = 1'b0;
            n_ticks = 12'(i2cmsc_pkg::cmd_clocks(i_item.mcode) * w_per * 2);
            n_ms[6] = 1'b0;
            if (i_item.mcode == i2cmsc_pkg::MC_START
                || i_item.mcode == i2cmsc_pkg::MC_STSEND) begin
                n_ms[7] = 1'b1;
                n_adr = 1'b1;
            end
            if (i_item.mcode == i2cmsc_pkg::MC_SEND || i_item.mcode == i2cmsc_pkg::MC_STSEND
                || i_item.mcode == i2cmsc_pkg::MC_AUTO) begin
                if (n_adr) begin
                    w_res.bus_op = i2cmsc_pkg::OP_START;
                    w_res.bus_byte = n_tx;
                    n_lack = i_item.tnack;
                    n_bus = !i_item.tnack;
                    n_rxd = n_tx[0];
                    n_adr = 1'b0;
                end else if (!r_bus || r_rxd) begin
                    n_lack = 1'b1;
                end else begin
                    w_res.bus_op = i2cmsc_pkg::OP_WRITE;
                    w_res.bus_byte = n_tx;
                    n_lack = i_item.tnack;
                end
            end
            if (i_item.mcode == i2cmsc_pkg::MC_ACKRD || i_item.mcode == i2cmsc_pkg::MC_STSEND
                || i_item.mcode == i2cmsc_pkg::MC_AUTO) n_smp = 1'b1;
            if (i_item.mcode == i2cmsc_pkg::MC_RECV || i_item.mcode == i2cmsc_pkg::MC_RECV2
                || i_item.mcode == i2cmsc_pkg::MC_RECVNK) begin
                if (r_bus && r_rxd) begin
                    n_rx = i_item.tbyte;
                    w_res.bus_op = (i_item.mcode == i2cmsc_pkg::MC_RECVNK)
                                   ? i2cmsc_pkg::OP_RDNAK : i2cmsc_pkg::OP_READ;
                end else begin
                    n_rx = i2cmsc_pkg::RX_EMPTY;
                end
            end
            if (i_item.mcode == i2cmsc_pkg::MC_NACK && r_bus && r_rxd && r_ms[0])
                w_res.bus_op = i2cmsc_pkg::OP_NACK;
            if (i_item.mcode == i2cmsc_pkg::MC_STOP) begin
                if (r_bus) w_res.bus_op = i2cmsc_pkg::OP_STOP;
                n_bus = 1'b0; n_adr = 1'b0; n_rxd = 1'b0; n_ms[7] = 1'b0;
            end
        end
        if (r_mode) w_res.irq = r_en && r_mirq && n_ms[6];
        else        w_res.irq = r_en && ((n_ss & i2cmsc_pkg::SL_FLAGS
                                          & {1'b0, r_sirq, 3'd0}) != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_oq[r_owp] <= w_res;
        if (!i_rst_n) begin
            r_en <= 1'b0; r_mode <= 1'b0; r_mirq <= 1'b0; r_auto <= 1'b0;
            r_speed <= '0; r_sirq <= '0; r_own <= '0;
            r_ms <= '0; r_ss <= '0; r_tx <= '0; r_rx <= '0; r_last <= '0;
            r_ticks <= '0; r_act <= 1'b0; r_bus <= 1'b0; r_adr <= 1'b0;
            r_rxd <= 1'b0; r_lack <= 1'b0; r_smp <= 1'b0;
            r_owp <= 1'b0; r_orp <= 1'b0; r_ocnt <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    i2cmsc_pkg::CFG_ENABLE: r_en    <= i_cfg_wdata[0];
                    i2cmsc_pkg::CFG_MODE:   r_mode  <= i_cfg_wdata[0];
                    i2cmsc_pkg::CFG_SPEED:  r_speed <= i_cfg_wdata[5:0];
                    i2cmsc_pkg::CFG_MIRQ:   r_mirq  <= i_cfg_wdata[0];
                    i2cmsc_pkg::CFG_SIRQ:   r_sirq  <= i_cfg_wdata[3:0];
                    i2cmsc_pkg::CFG_AUTO:   r_auto  <= i_cfg_wdata[0];
                    i2cmsc_pkg::CFG_OWNADR: r_own   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_take) begin
                r_ms <= n_ms; r_ss <= n_ss; r_tx <= n_tx; r_rx <= n_rx;
                r_last <= n_last; r_ticks <= n_ticks; r_act <= n_act;
                r_bus <= n_bus; r_adr <= n_adr; r_rxd <= n_rxd;
                r_lack <= n_lack; r_smp <= n_smp;
                r_owp <= ~r_owp;
            end
            if (i_pop && !o_empty) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, o_take} - {1'b0, i_pop && !o_empty};
        end
    end
endmodule
`default_nettype wire

FILE: src/i2c_master_slave_controller.sv
// Top level of the register-level I2C master/slave controller.
// Every item (register read or write, tick, slave event) yields exactly one
// result transfer. The block sustains one item per clock while results are
// popped: a two-entry input queue feeds a combinational execute stage, whose
// results land in a two-entry output queue. A master command is issued on
// the item that carries it, and its bus operation is reported on that item's
// result; done_res comes on the tick that ends the busy time of
// clocks*2*(speed*2+4) ticks. Configuration writes are applied at once and
// should be made while the block is idle.
`default_nettype none
module i2c_master_slave_controller (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  wire  [2:0] i_command,
    input  wire  [3:0] i_reg_index,
    input  wire  [7:0] i_wdata,
    input  wire        i_target_nack,
    input  wire  [7:0] i_target_byte,
    input  wire  [1:0] i_slave_kind,
    input  wire  [7:0] i_slave_byte,
    input  wire        i_slave_nack,
    output logic       empty,
    input  wire        pop,
    output logic [7:0] o_rdata,
    output logic       o_irq,
    output logic [2:0] o_bus_op,
    output logic [7:0] o_bus_byte,
    output logic       o_done_res,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_index,
    input  wire  [7:0] i_cfg_wdata
);
    i2cmsc_pkg::t_item w_item;
    i2cmsc_pkg::t_res  w_res;
    logic w_valid, w_take, w_auto;

    i2cmsc_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_command, .i_reg_index, .i_wdata, .i_target_nack, .i_target_byte,
        .i_slave_kind, .i_slave_byte, .i_slave_nack,
        .i_auto_send(w_auto), .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    i2cmsc_engine u_engine (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .o_auto_send(w_auto), .i_valid(w_valid), .i_item(w_item), .o_take(w_take),
        .o_empty(empty), .i_pop(pop), .o_res(w_res)
    );

    assign o_rdata    = w_res.rdata;
    assign o_irq      = w_res.irq;
    assign o_bus_op   = w_res.bus_op;
    assign o_bus_byte = w_res.bus_byte;
    assign o_done_res = w_res.done;
endmodule
`default_nettype wire
